// ===== rtl/core/memory_bank_rotating_arbiter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the memory bank arbiter
// Shorthand for clocked assertions with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef MEMORY_BANK_ROTATING_ARBITER_MACROS_SVH
`define MEMORY_BANK_ROTATING_ARBITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mbra_pkg.sv =====
// ----------------------------------------------------------------------------
// Memory bank arbiter package
// Field widths, operation codes, register indexes and shared control types.
// ----------------------------------------------------------------------------
package mbra_pkg;

   localparam int OPCODE_W    = 2;
   localparam int PROC_IDX_W  = 3;
   localparam int MOD_IDX_W   = 4;
   localparam int OUT_CNT_W   = 32;
   localparam int PROCS_CFG_W = 4;
   localparam int MODS_CFG_W  = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   localparam int PROCS_DEF       = 8;
   localparam int MODULES_DEF     = 16;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCS_IN_USE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULES_IN_USE = 1'd1;

   localparam logic [PROCS_CFG_W-1:0] PROCS_CFG_RST = 4'd8;
   localparam logic [MODS_CFG_W-1:0]  MODS_CFG_RST  = 5'd16;

   typedef struct packed {
      logic write_req;
      logic clear_stats;
      logic start_tick;
      logic read;
      logic update;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic granted;
   } status_type;

endpackage

// ===== rtl/core/mbra_if.sv =====
// ----------------------------------------------------------------------------
// Memory bank arbiter channels
// Valid/ready channels for operation beats in and processor reports out.
// ----------------------------------------------------------------------------
interface mbra_req_if import mbra_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [PROC_IDX_W-1:0] proc_index;
   logic [MOD_IDX_W-1:0]  module_index;

   modport source(output valid, output opcode, output proc_index, output module_index,
                  input ready);
   modport sink(input valid, input opcode, input proc_index, input module_index,
                output ready);
endinterface

interface mbra_rsp_if import mbra_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PROC_IDX_W-1:0] proc_index_out;
   logic                  granted;
   logic [OUT_CNT_W-1:0]  wait_cycles;
   logic [OUT_CNT_W-1:0]  grant_count;
   logic [OUT_CNT_W-1:0]  wait_total;
   logic                  last;

   modport source(output valid, output proc_index_out, output granted, output wait_cycles,
                  output grant_count, output wait_total, output last, input ready);
   modport sink(input valid, input proc_index_out, input granted, input wait_cycles,
                input grant_count, input wait_total, input last, output ready);
endinterface

// ===== rtl/core/mbra_datapath.sv =====
// ----------------------------------------------------------------------------
// Memory bank arbiter datapath
// Request and statistics memories, module busy mask and the result register.
// ----------------------------------------------------------------------------
module mbra_datapath import mbra_pkg::*; #(
   parameter int PROCS       = PROCS_DEF,
   parameter int MODULES     = MODULES_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int PIDX_W      = (PROCS > 1) ? $clog2(PROCS) : 1,
   parameter int MLIM_W      = $clog2(MODULES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [PIDX_W-1:0]     scan_idx,
   input  logic [MLIM_W-1:0]     mods_lim,
   input  logic [PROC_IDX_W-1:0] req_proc_index,
   input  logic [MOD_IDX_W-1:0]  req_module_index,
   mbra_rsp_if.source            rsp
);

   localparam int REQ_W = (MODULES > 1) ? $clog2(MODULES) : 1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] grants;
      logic [COUNT_WIDTH-1:0] total;
      logic [COUNT_WIDTH-1:0] cur;
   } stat_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   logic [REQ_W-1:0] req_mem [PROCS];
   stat_type         stat_mem [PROCS];

   logic [PROCS-1:0]   req_vld_ff, req_vld_in;
   logic [PROCS-1:0]   stat_vld_ff, stat_vld_in;
   logic [MODULES-1:0] busy_ff, busy_in;
   logic [REQ_W-1:0]   req_rd_ff;
   stat_type           stat_rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PROC_IDX_W-1:0] out_proc_ff;
   logic                  out_granted_ff;
   logic [OUT_CNT_W-1:0]  out_wait_ff;
   logic [OUT_CNT_W-1:0]  out_grants_ff;
   logic [OUT_CNT_W-1:0]  out_total_ff;
   logic                  out_last_ff;

   logic                   write_ok;
   logic [REQ_W-1:0]       req_val;
   stat_type               stat_val;
   stat_type               stat_new;
   logic [COUNT_WIDTH-1:0] wait_now;
   logic                   grant_now;

   assign write_ok = cmd.write_req
                     && (16'(req_proc_index) < 16'(PROCS))
                     && (16'(req_module_index) < 16'(mods_lim));

   assign req_val  = req_vld_ff[scan_idx] ? req_rd_ff : '0;
   assign stat_val = stat_vld_ff[scan_idx] ? stat_rd_ff : '0;
   assign wait_now = sat_add(stat_val.cur, COUNT_WIDTH'(1));
   assign grant_now = !busy_ff[req_val];

   always_comb begin
      stat_new.grants = grant_now ? sat_add(stat_val.grants, COUNT_WIDTH'(1)) : stat_val.grants;
      stat_new.total  = grant_now ? sat_add(stat_val.total, wait_now) : stat_val.total;
      stat_new.cur    = grant_now ? '0 : wait_now;
   end

   always_comb begin
      req_vld_in = req_vld_ff;
      if (write_ok) begin
         req_vld_in[PIDX_W'(req_proc_index)] = 1'b1;
      end
   end

   always_comb begin
      stat_vld_in = stat_vld_ff;
      if (cmd.clear_stats) begin
         stat_vld_in = '0;
      end else if (cmd.update) begin
         stat_vld_in[scan_idx] = 1'b1;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (cmd.start_tick) begin
         busy_in = '0;
      end else if (cmd.update && grant_now) begin
         busy_in[req_val] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff   <= '0;
         stat_vld_ff  <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_vld_ff   <= req_vld_in;
         stat_vld_ff  <= stat_vld_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_ok) begin
         req_mem[PIDX_W'(req_proc_index)] <= REQ_W'(req_module_index);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         stat_mem[scan_idx] <= stat_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         req_rd_ff  <= req_mem[scan_idx];
         stat_rd_ff <= stat_mem[scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_proc_ff    <= PROC_IDX_W'(scan_idx);
         out_granted_ff <= grant_now;
         out_wait_ff    <= OUT_CNT_W'(wait_now);
         out_grants_ff  <= OUT_CNT_W'(stat_new.grants);
         out_total_ff   <= OUT_CNT_W'(stat_new.total);
         out_last_ff    <= cmd.last;
      end
   end

   assign status = {!rsp_valid_ff || rsp.ready, grant_now};

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.proc_index_out = out_proc_ff;
   assign rsp.granted        = out_granted_ff;
   assign rsp.wait_cycles    = out_wait_ff;
   assign rsp.grant_count    = out_grants_ff;
   assign rsp.wait_total     = out_total_ff;
   assign rsp.last           = out_last_ff;

endmodule

// ===== rtl/core/mbra_ctrl.sv =====
// ----------------------------------------------------------------------------
// Memory bank arbiter controller
// Decodes operation beats and sequences the rotating scan over processors.
// ----------------------------------------------------------------------------
`include "memory_bank_rotating_arbiter_macros.svh"

module mbra_ctrl import mbra_pkg::*; #(
   parameter int PROCS  = PROCS_DEF,
   parameter int PIDX_W = (PROCS > 1) ? $clog2(PROCS) : 1,
   parameter int CNT_W  = $clog2(PROCS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   input  logic [CNT_W-1:0]    n_procs,
   output cmd_type             cmd,
   input  status_type          status,
   output logic [PIDX_W-1:0]   scan_idx
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_NORM   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [PIDX_W-1:0] idx_ff, idx_in;
   logic [PIDX_W-1:0] base_ff, base_in;
   logic [PIDX_W-1:0] new_base_ff, new_base_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              denied_ff, denied_in;
   logic              accept;
   logic              at_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign at_last   = (cnt_ff == n_procs - CNT_W'(1));
   assign scan_idx  = idx_ff;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      base_in     = base_ff;
      new_base_in = new_base_ff;
      cnt_in      = cnt_ff;
      denied_in   = denied_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_WRITE: begin
                     cmd.write_req = 1'b1;
                  end
                  OP_CLEAR: begin
                     cmd.clear_stats = 1'b1;
                     base_in         = '0;
                  end
                  OP_TICK: begin
                     cmd.start_tick = 1'b1;
                     idx_in         = base_ff;
                     cnt_in         = '0;
                     denied_in      = 1'b0;
                     state_in       = ST_NORM;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NORM: begin
            if (CNT_W'(idx_ff) >= n_procs) begin
               idx_in = PIDX_W'(CNT_W'(idx_ff) - n_procs);
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.slot_free) begin
               cmd.update = 1'b1;
               cmd.last   = at_last;
               if (!status.granted && !denied_ff) begin
                  denied_in   = 1'b1;
                  new_base_in = idx_ff;
               end
               if (at_last) begin
                  if (denied_ff) begin
                     base_in = new_base_ff;
                  end else if (!status.granted) begin
                     base_in = idx_ff;
                  end
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (CNT_W'(idx_ff) + CNT_W'(1) == n_procs) begin
                     idx_in = '0;
                  end else begin
                     idx_in = PIDX_W'(CNT_W'(idx_ff) + CNT_W'(1));
                  end
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         base_ff     <= '0;
         new_base_ff <= '0;
         cnt_ff      <= '0;
         denied_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         base_ff     <= base_in;
         new_base_ff <= new_base_in;
         cnt_ff      <= cnt_in;
         denied_ff   <= denied_in;
      end
   end

   `MBRA_ASSERT_SAME(a_update_has_slot, clock, reset, cmd.update, status.slot_free, "Result register overwritten while a beat still waits.")
   `MBRA_ASSERT_NEXT(a_tick_starts_scan, clock, reset, accept && (req_opcode == OP_TICK), state_ff == ST_NORM, "Tick beat did not start a scan.")
   `MBRA_ASSERT_NEXT(a_update_advances, clock, reset, (state_ff == ST_UPDATE) && status.slot_free, (state_ff == ST_READ) || (state_ff == ST_IDLE), "Scan failed to advance after a result was loaded.")

endmodule

// ===== rtl/core/memory_bank_rotating_arbiter.sv =====
// ----------------------------------------------------------------------------
// Memory bank arbiter with rotating priority
// A tick beat first brings the stored base into the active range, with one
// subtraction per wrap when the stored base lies beyond the active
// processors; then for each of the n active processors it reads the request
// and statistics from memory, then arbitrates against the module busy mask
// and writes back. The request port is not ready while a scan runs. Request
// writes, clears and configuration writes give no result. Each scanned
// processor yields one result beat, in scan order, and a stalled result port
// holds the scan until the output register is free.
// ----------------------------------------------------------------------------
module memory_bank_rotating_arbiter import mbra_pkg::*; #(
   parameter int PROCS       = PROCS_DEF,
   parameter int MODULES     = MODULES_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mbra_req_if.sink              req_ch,
   mbra_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PIDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int CNT_W  = $clog2(PROCS + 1);
   localparam int MLIM_W = $clog2(MODULES + 1);

   logic [PROCS_CFG_W-1:0] procs_cfg_ff, procs_cfg_in;
   logic [MODS_CFG_W-1:0]  mods_cfg_ff, mods_cfg_in;
   logic [CNT_W-1:0]       n_procs;
   logic [MLIM_W-1:0]      mods_lim;
   cmd_type                cmd;
   status_type             status;
   logic [PIDX_W-1:0]      scan_idx;

   always_comb begin
      procs_cfg_in = procs_cfg_ff;
      mods_cfg_in  = mods_cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROCS_IN_USE:   procs_cfg_in = csr_wdata[PROCS_CFG_W-1:0];
            CSR_MODULES_IN_USE: mods_cfg_in  = csr_wdata[MODS_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         procs_cfg_ff <= PROCS_CFG_RST;
         mods_cfg_ff  <= MODS_CFG_RST;
      end else begin
         procs_cfg_ff <= procs_cfg_in;
         mods_cfg_ff  <= mods_cfg_in;
      end
   end

   // Out-of-range settings are clamped to the span that the block supports.
   always_comb begin
      if (procs_cfg_ff == '0) begin
         n_procs = CNT_W'(1);
      end else if (16'(procs_cfg_ff) > 16'(PROCS)) begin
         n_procs = CNT_W'(PROCS);
      end else begin
         n_procs = CNT_W'(procs_cfg_ff);
      end
      if (mods_cfg_ff == '0) begin
         mods_lim = MLIM_W'(1);
      end else if (16'(mods_cfg_ff) > 16'(MODULES)) begin
         mods_lim = MLIM_W'(MODULES);
      end else begin
         mods_lim = MLIM_W'(mods_cfg_ff);
      end
   end

   mbra_ctrl #(
      .PROCS  (PROCS),
      .PIDX_W (PIDX_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .n_procs    (n_procs),
      .cmd        (cmd),
      .status     (status),
      .scan_idx   (scan_idx)
   );

   mbra_datapath #(
      .PROCS       (PROCS),
      .MODULES     (MODULES),
      .COUNT_WIDTH (COUNT_WIDTH),
      .PIDX_W      (PIDX_W),
      .MLIM_W      (MLIM_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .scan_idx         (scan_idx),
      .mods_lim         (mods_lim),
      .req_proc_index   (req_ch.proc_index),
      .req_module_index (req_ch.module_index),
      .rsp              (rsp_ch)
   );

endmodule
